// ===== rtl/lts_pkg.sv =====
// Package for the line trajectory sampler.
// Holds shared widths, register map, state types and the output saturation function.
// No dependencies.
package lts_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_FRAC_BITS  = 8;

    localparam int IN_W      = 16;
    localparam int PT_W      = 24;
    localparam int STEP_W    = 10;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 2;
    localparam int SAT_W     = 48;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);
    localparam logic [ADDR_W-1:0] REG_STEP   = ADDR_W'(0);

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_CALC,
        TOP_EMIT
    } top_state_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_SQX,
        ENG_SQY,
        ENG_SUM,
        ENG_ROOT,
        ENG_DIVN,
        ENG_DIVX,
        ENG_DIVY
    } eng_state_t;

    function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        logic signed [PT_W-1:0]  r;
        hi = SAT_W'(8388607);
        lo = -SAT_W'(8388608);
        if (v > hi)
        begin
            r = PT_W'(hi);
        end
        else if (v < lo)
        begin
            r = PT_W'(lo);
        end
        else
        begin
            r = v[PT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/line_trajectory_sampler.sv =====
// Line trajectory sampler: one input transaction yields a run of 1 to MAX_POINTS points.
// The setup runs the square root and one division, plus two more divisions when the step
// count is 2 or more, all on the shared subtract unit. Points then leave one per cycle
// while point_ready holds; a new input is accepted once the last point is registered.
// Reset is asynchronous and active low; it clears control state and sets step_size to 1.
module line_trajectory_sampler
    import lts_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic signed [IN_W-1:0]  start_x,
    input  logic signed [IN_W-1:0]  start_y,
    input  logic signed [IN_W-1:0]  end_x,
    input  logic signed [IN_W-1:0]  end_y,
    output logic                    point_valid,
    input  logic                    point_ready,
    output logic signed [PT_W-1:0]  point_x,
    output logic signed [PT_W-1:0]  point_y,
    output logic                    last,
    output logic                    clipped
);

    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int DW = COORD_BITS + 1 + FRAC_BITS;
    localparam int PW = DW + 1;

    top_state_t state_reg;
    top_state_t state_next;

    logic [STEP_W-1:0]           step_reg;
    logic signed [COORD_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [PW-1:0]        px_reg, py_reg;
    logic [NW-1:0]               rx_reg, ry_reg;
    logic [NW-1:0]               left_reg;
    logic                        out_valid_reg;
    logic signed [PT_W-1:0]      point_x_reg, point_y_reg;
    logic                        last_reg, clipped_reg;

    logic                        accept;
    logic                        cfg_wr;
    logic                        load_out;
    logic                        eng_done;
    logic [NW-1:0]               eng_n;
    logic                        eng_clip;
    logic signed [DW:0]          eng_qx, eng_qy;
    logic [NW-1:0]               eng_rx, eng_ry;
    logic signed [NW:0]          rx_dif, ry_dif;
    logic signed [PW-1:0]        px_step, py_step;
    logic [NW-1:0]               rx_step, ry_step;

    lts_engine #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .MAX_POINTS (MAX_POINTS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .sx    (sx_reg),
        .sy    (sy_reg),
        .ex    (ex_reg),
        .ey    (ey_reg),
        .step  (step_reg),
        .done  (eng_done),
        .n_cnt (eng_n),
        .clip  (eng_clip),
        .qx    (eng_qx),
        .qy    (eng_qy),
        .rx    (eng_rx),
        .ry    (eng_ry)
    );

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = DATA_W'(step_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TOP_IDLE:
            begin
                if (accept)
                begin
                    state_next = TOP_CALC;
                end
            end
            TOP_CALC:
            begin
                if (eng_done)
                begin
                    state_next = TOP_EMIT;
                end
            end
            TOP_EMIT:
            begin
                if (load_out && (left_reg == '0))
                begin
                    state_next = TOP_IDLE;
                end
            end
            default: state_next = TOP_IDLE;
        endcase
    end

    always_comb
    begin
        item_ready = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            TOP_IDLE: item_ready = 1'b1;
            TOP_EMIT: load_out   = !out_valid_reg || point_ready;
            default:
            begin
                item_ready = 1'b0;
                load_out   = 1'b0;
            end
        endcase
    end

    assign accept = item_valid && item_ready;

    assign rx_dif = $signed({1'b0, rx_reg}) - $signed({1'b0, eng_rx});
    assign ry_dif = $signed({1'b0, ry_reg}) - $signed({1'b0, eng_ry});
    assign px_step = rx_dif[NW] ? (px_reg - PW'(eng_qx) - PW'(1)) : (px_reg - PW'(eng_qx));
    assign py_step = ry_dif[NW] ? (py_reg - PW'(eng_qy) - PW'(1)) : (py_reg - PW'(eng_qy));
    assign rx_step = rx_dif[NW] ? NW'(rx_dif + $signed({1'b0, eng_n})) : rx_dif[NW-1:0];
    assign ry_step = ry_dif[NW] ? NW'(ry_dif + $signed({1'b0, eng_n})) : ry_dif[NW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TOP_IDLE;
            step_reg      <= STEP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && ((paddr >> 2) == REG_STEP))
            begin
                step_reg <= pwdata[STEP_W-1:0];
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (point_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg <= $signed(COORD_BITS'($unsigned(start_x)));
            sy_reg <= $signed(COORD_BITS'($unsigned(start_y)));
            ex_reg <= $signed(COORD_BITS'($unsigned(end_x)));
            ey_reg <= $signed(COORD_BITS'($unsigned(end_y)));
        end
        if ((state_reg == TOP_CALC) && eng_done)
        begin
            px_reg   <= PW'(ex_reg) <<< FRAC_BITS;
            py_reg   <= PW'(ey_reg) <<< FRAC_BITS;
            rx_reg   <= '0;
            ry_reg   <= '0;
            left_reg <= (eng_n > NW'(1)) ? (eng_n - NW'(1)) : '0;
        end
        if (load_out)
        begin
            point_x_reg <= sat_pt(SAT_W'(px_reg));
            point_y_reg <= sat_pt(SAT_W'(py_reg));
            last_reg    <= (left_reg == '0);
            clipped_reg <= eng_clip;
            px_reg      <= px_step;
            py_reg      <= py_step;
            rx_reg      <= rx_step;
            ry_reg      <= ry_step;
            left_reg    <= left_reg - NW'(1);
        end
    end

    assign point_valid = out_valid_reg;
    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign last        = last_reg;
    assign clipped     = clipped_reg;

endmodule

// ===== rtl/lts_engine.sv =====
// Setup arithmetic of the line trajectory sampler: squares, square root and up to three divisions.
// One multiplier and one shared compare-subtract unit run under a small sequencer.
// Depends on lts_pkg.
module lts_engine
    import lts_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    localparam int NW        = $clog2(MAX_POINTS + 1),
    localparam int DW        = COORD_BITS + 1 + FRAC_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] sx,
    input  logic signed [COORD_BITS-1:0] sy,
    input  logic signed [COORD_BITS-1:0] ex,
    input  logic signed [COORD_BITS-1:0] ey,
    input  logic [STEP_W-1:0]            step,
    output logic                         done,
    output logic [NW-1:0]                n_cnt,
    output logic                         clip,
    output logic signed [DW:0]           qx,
    output logic signed [DW:0]           qy,
    output logic [NW-1:0]                rx,
    output logic [NW-1:0]                ry
);

    localparam int AX_W     = COORD_BITS + 1;
    localparam int SQ_W     = 2 * COORD_BITS + 4;
    localparam int HALF     = SQ_W / 2;
    localparam int RW       = COORD_BITS + 2;
    localparam int QW       = (DW > RW) ? DW : RW;
    localparam int ITER_MAX = (QW > HALF) ? QW : HALF;
    localparam int CNT_W    = $clog2(ITER_MAX);
    localparam logic [SQ_W-1:0] BIT0 = SQ_W'(1) << (SQ_W - 2);

    eng_state_t state_reg;
    eng_state_t state_next;

    logic [2*AX_W-1:0] prod_reg, prod_next;
    logic [SQ_W-1:0]   v_reg, v_next;
    logic [SQ_W-1:0]   res_reg, res_next;
    logic [SQ_W-1:0]   bit_reg, bit_next;
    logic [QW-1:0]     quo_reg, quo_next;
    logic [STEP_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NW-1:0]     n_reg, n_next;
    logic              clip_reg, clip_next;
    logic signed [DW:0] qx_reg, qx_next;
    logic signed [DW:0] qy_reg, qy_next;
    logic [NW-1:0]     rx_reg, rx_next;
    logic [NW-1:0]     ry_reg, ry_next;

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [AX_W-1:0]   ax;
    logic [AX_W-1:0]   ay;
    logic [AX_W-1:0]   mul_op;
    logic [2*AX_W-1:0] product;

    logic [SQ_W-1:0]   alu_a;
    logic [SQ_W-1:0]   alu_b;
    logic [SQ_W:0]     alu_full;
    logic              alu_ge;
    logic [SQ_W-1:0]   alu_diff;

    logic [STEP_W:0]   rem_sh;
    logic [QW-1:0]     quo_step;
    logic [STEP_W-1:0] rem_step;
    logic [SQ_W-1:0]   res_nx;
    logic              big;
    logic [NW-1:0]     n_calc;
    logic              root_last;
    logic              div_last;

    function automatic logic signed [DW:0] fix_quo(input logic neg, input logic [QW-1:0] q,
                                                   input logic [STEP_W-1:0] r);
        logic [DW:0] q0;
        logic [DW:0] qr;
        q0 = {1'b0, q[DW-1:0]};
        if (neg && (r != '0))
        begin
            qr = ~q0;
        end
        else if (neg)
        begin
            qr = -q0;
        end
        else
        begin
            qr = q0;
        end
        return $signed(qr);
    endfunction

    function automatic logic [NW-1:0] fix_rem(input logic neg, input logic [STEP_W-1:0] r,
                                              input logic [NW-1:0] n);
        logic [NW-1:0] rr;
        if (neg && (r != '0))
        begin
            rr = n - r[NW-1:0];
        end
        else
        begin
            rr = r[NW-1:0];
        end
        return rr;
    endfunction

    assign dx = $signed({ex[COORD_BITS-1], ex}) - $signed({sx[COORD_BITS-1], sx});
    assign dy = $signed({ey[COORD_BITS-1], ey}) - $signed({sy[COORD_BITS-1], sy});
    assign ax = dx[COORD_BITS] ? AX_W'(-dx) : AX_W'(dx);
    assign ay = dy[COORD_BITS] ? AX_W'(-dy) : AX_W'(dy);
    assign mul_op  = (state_reg == ENG_SQX) ? ax : ay;
    assign product = (2*AX_W)'(mul_op) * (2*AX_W)'(mul_op);

    assign alu_full = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_ge   = ~alu_full[SQ_W];
    assign alu_diff = alu_full[SQ_W-1:0];

    assign rem_sh   = {rem_reg, quo_reg[QW-1]};
    assign quo_step = {quo_reg[QW-2:0], alu_ge};
    assign rem_step = alu_ge ? alu_diff[STEP_W-1:0] : rem_sh[STEP_W-1:0];
    assign big      = quo_step > QW'(MAX_POINTS);
    assign n_calc   = big ? NW'(MAX_POINTS) : quo_step[NW-1:0];

    assign root_last = (cnt_reg == CNT_W'(HALF - 1));
    assign div_last  = (cnt_reg == CNT_W'(QW - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE:
            begin
                if (start)
                begin
                    state_next = ENG_SQX;
                end
            end
            ENG_SQX:  state_next = ENG_SQY;
            ENG_SQY:  state_next = ENG_SUM;
            ENG_SUM:  state_next = ENG_ROOT;
            ENG_ROOT:
            begin
                if (root_last)
                begin
                    state_next = ENG_DIVN;
                end
            end
            ENG_DIVN:
            begin
                if (div_last)
                begin
                    state_next = (n_calc > NW'(1)) ? ENG_DIVX : ENG_IDLE;
                end
            end
            ENG_DIVX:
            begin
                if (div_last)
                begin
                    state_next = ENG_DIVY;
                end
            end
            ENG_DIVY:
            begin
                if (div_last)
                begin
                    state_next = ENG_IDLE;
                end
            end
            default:  state_next = ENG_IDLE;
        endcase
    end

    always_comb
    begin
        done = 1'b0;
        case (state_reg)
            ENG_DIVN: done = div_last && (n_calc <= NW'(1));
            ENG_DIVY: done = div_last;
            default:  done = 1'b0;
        endcase
    end

    always_comb
    begin
        prod_next = prod_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        clip_next = clip_reg;
        qx_next   = qx_reg;
        qy_next   = qy_reg;
        rx_next   = rx_reg;
        ry_next   = ry_reg;
        alu_a     = '0;
        alu_b     = '0;
        res_nx    = res_reg >> 1;
        case (state_reg)
            ENG_IDLE:
            begin
                cnt_next = '0;
            end
            ENG_SQX:
            begin
                prod_next = product;
            end
            ENG_SQY:
            begin
                prod_next = product;
                v_next    = SQ_W'(prod_reg);
            end
            ENG_SUM:
            begin
                v_next   = v_reg + SQ_W'(prod_reg);
                res_next = '0;
                bit_next = BIT0;
                cnt_next = '0;
            end
            ENG_ROOT:
            begin
                alu_a = v_reg;
                alu_b = res_reg | bit_reg;
                if (alu_ge)
                begin
                    v_next = alu_diff;
                    res_nx = (res_reg >> 1) | bit_reg;
                end
                res_next = res_nx;
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + CNT_W'(1);
                if (root_last)
                begin
                    quo_next = QW'(res_nx);
                    rem_next = '0;
                    dvs_next = (step == '0) ? STEP_W'(1) : step;
                    cnt_next = '0;
                end
            end
            ENG_DIVN, ENG_DIVX, ENG_DIVY:
            begin
                alu_a    = SQ_W'(rem_sh);
                alu_b    = SQ_W'(dvs_reg);
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (div_last)
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    if (state_reg == ENG_DIVN)
                    begin
                        n_next    = n_calc;
                        clip_next = big;
                        quo_next  = QW'(ax) << FRAC_BITS;
                        dvs_next  = STEP_W'(n_calc);
                    end
                    else if (state_reg == ENG_DIVX)
                    begin
                        qx_next  = fix_quo(dx[COORD_BITS], quo_step, rem_step);
                        rx_next  = fix_rem(dx[COORD_BITS], rem_step, n_reg);
                        quo_next = QW'(ay) << FRAC_BITS;
                    end
                    else
                    begin
                        qy_next = fix_quo(dy[COORD_BITS], quo_step, rem_step);
                        ry_next = fix_rem(dy[COORD_BITS], rem_step, n_reg);
                    end
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        n_reg    <= n_next;
        clip_reg <= clip_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
    end

    assign n_cnt = n_next;
    assign clip  = clip_next;
    assign qx    = qx_next;
    assign qy    = qy_next;
    assign rx    = rx_next;
    assign ry    = ry_next;

endmodule

// ===== rtl/lts_checker.sv =====
// Port-level checks for the line trajectory sampler, bound to the top level.
// Depends on lts_pkg and line_trajectory_sampler.
module lts_checker
    import lts_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   psel,
    input logic                   penable,
    input logic                   pwrite,
    input logic                   pready,
    input logic [DATA_W-1:0]      pwdata,
    input logic [DATA_W-1:0]      prdata,
    input logic                   item_valid,
    input logic                   item_ready,
    input logic                   point_valid,
    input logic                   point_ready,
    input logic signed [PT_W-1:0] point_x,
    input logic signed [PT_W-1:0] point_y,
    input logic                   last,
    input logic                   clipped
);

    // A result that is not taken holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_ready |=> point_valid && $stable(point_x) && $stable(point_y)
            && $stable(last) && $stable(clipped))
    else $error("stalled point changed");

    // The block is busy after it takes an input transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
    else $error("input accepted while busy");

    // A new point only appears while a run is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(point_valid) |-> $past(!item_ready))
    else $error("point appeared without a run");

    // Inside a run, the next point follows at once and keeps the clipped flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready && !last |=> point_valid && (clipped == $past(clipped)))
    else $error("run broken before its last point");

    // A register write is visible on the read data.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready |=> prdata[STEP_W-1:0] == $past(pwdata[STEP_W-1:0]))
    else $error("step register readback mismatch");

endmodule

bind line_trajectory_sampler lts_checker u_lts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .last        (last),
    .clipped     (clipped)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for line_trajectory_sampler: directed runs, random traffic phases,
// input backpressure and a paced sender, checked point by point against a built-in predictor.
// Depends on rtl/lts_pkg.sv and rtl/line_trajectory_sampler.sv.
`timescale 1ns / 100ps

module testbench;
    import lts_pkg::*;

    localparam int MAX_PTS   = DEF_MAX_POINTS;
    localparam int FRAC      = DEF_FRAC_BITS;
    localparam int IDLE_PAD  = 8;
    localparam int END_PAD   = 200;
    localparam int HOLD_OFF  = 400;
    localparam int MAX_SHOWN = 20;

    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic                   last;
        logic                   clipped;
    } traj_point_t;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [DATA_W-1:0]      pwdata;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   item_valid;
    logic                   item_ready;
    logic signed [IN_W-1:0] start_x;
    logic signed [IN_W-1:0] start_y;
    logic signed [IN_W-1:0] end_x;
    logic signed [IN_W-1:0] end_y;
    logic                   point_valid;
    logic                   point_ready;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic                   last;
    logic                   clipped;

    traj_point_t       expected_points[$];
    traj_point_t       want_point;
    logic [STEP_W-1:0] step_setting;
    int                sender_idle_pct;
    int                receiver_stall_pct;
    int                hold_off_cycles;
    int                mismatch_count;
    int                runs_sent;
    int                clipped_runs;
    int                points_seen;
    int                runs_seen;

    line_trajectory_sampler u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .last        (last),
        .clipped     (clipped)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_SHOWN)
        begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [PT_W-1:0] got,
                                 input logic [PT_W-1:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("point %0d field %s: got %h, expected %h",
                                      points_seen, name, got, want));
        end
    endtask

    function automatic longint floor_sqrt(input longint v);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 17;
        while (b != 0)
        begin
            if ((r + b) * (r + b) <= v)
            begin
                r = r + b;
            end
            b = b >> 1;
        end
        return r;
    endfunction

    function automatic logic signed [PT_W-1:0] clamp_fixed(input longint v);
        if (v > 64'sd8388607)
        begin
            return 24'sh7FFFFF;
        end
        if (v < -64'sd8388608)
        begin
            return 24'sh800000;
        end
        return v[PT_W-1:0];
    endfunction

    function automatic logic signed [PT_W-1:0] lerp_fixed(input longint s, input longint d,
                                                          input longint i, input longint n);
        longint num;
        longint q;
        num = (s * n + d * i) * (longint'(1) << FRAC);
        q = num / n;
        if ((num % n) != 0 && num < 0)
        begin
            q = q - 1;
        end
        return clamp_fixed(q);
    endfunction

    // Expected run for one transaction: the end point first, then the interior points
    // walking back toward the start.
    function automatic void predict_trajectory(input longint sx, input longint sy,
                                               input longint ex, input longint ey);
        longint      dx;
        longint      dy;
        longint      n;
        longint      eff_step;
        int          count;
        logic        clip;
        traj_point_t p;
        dx = ex - sx;
        dy = ey - sy;
        eff_step = (step_setting == '0) ? 1 : longint'(step_setting);
        n = floor_sqrt(dx * dx + dy * dy) / eff_step;
        clip = 1'b0;
        if (n > MAX_PTS)
        begin
            n = MAX_PTS;
            clip = 1'b1;
        end
        count = (n < 1) ? 1 : int'(n);
        runs_sent++;
        if (clip)
        begin
            clipped_runs++;
        end
        p.x = clamp_fixed(ex * (longint'(1) << FRAC));
        p.y = clamp_fixed(ey * (longint'(1) << FRAC));
        p.last = (count == 1);
        p.clipped = clip;
        expected_points.push_back(p);
        for (int k = 1; k < count; k++)
        begin
            p.x = lerp_fixed(sx, dx, n - k, n);
            p.y = lerp_fixed(sy, dy, n - k, n);
            p.last = (k == count - 1);
            p.clipped = clip;
            expected_points.push_back(p);
        end
    endfunction

    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            point_ready <= 1'b0;
            hold_off_cycles--;
        end
        else if (rst_n)
        begin
            point_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && point_valid && point_ready)
        begin
            if (expected_points.size() == 0)
            begin
                report_mismatch($sformatf("unexpected point %h,%h", point_x, point_y));
            end
            else
            begin
                want_point = expected_points.pop_front();
                compare_field("point_x", point_x, want_point.x);
                compare_field("point_y", point_y, want_point.y);
                compare_field("last", PT_W'(last), PT_W'(want_point.last));
                compare_field("clipped", PT_W'(clipped), PT_W'(want_point.clipped));
                if (want_point.last)
                begin
                    runs_seen++;
                end
            end
            points_seen++;
        end
    end

    task automatic send_item(input logic signed [IN_W-1:0] sx, input logic signed [IN_W-1:0] sy,
                             input logic signed [IN_W-1:0] ex, input logic signed [IN_W-1:0] ey);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        start_x <= sx;
        start_y <= sy;
        end_x <= ex;
        end_y <= ey;
        do
        begin
            @(posedge clk);
        end
        while (!item_ready);
        predict_trajectory(sx, sy, ex, ey);
    endtask

    task automatic wait_for_results(input int pad);
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (pad) @(posedge clk);
    endtask

    task automatic write_step_size(input logic [STEP_W-1:0] value);
        logic [DATA_W-1:0] readback;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_STEP;
        pwdata <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback[STEP_W-1:0] !== value)
        begin
            report_mismatch($sformatf("step_size read back %h, expected %h",
                                      readback[STEP_W-1:0], value));
        end
        step_setting = value;
    endtask

    // Most random transactions aim at a chosen step count so every run length shows up;
    // the rest are unconstrained coordinates.
    task automatic send_random_run();
        longint eff_step;
        longint len;
        longint dx;
        longint dy;
        longint sx;
        longint sy;
        longint adx;
        longint ady;
        if ($urandom_range(0, 99) < 20)
        begin
            send_item(IN_W'($urandom), IN_W'($urandom), IN_W'($urandom), IN_W'($urandom));
        end
        else
        begin
            eff_step = (step_setting == '0) ? 1 : longint'(step_setting);
            len = $urandom_range(0, MAX_PTS + 6) * eff_step + $urandom_range(0, eff_step - 1);
            dx = $urandom_range(0, len);
            dy = floor_sqrt(len * len - dx * dx);
            adx = (dx > 65535) ? 65535 : dx;
            ady = (dy > 65535) ? 65535 : dy;
            dx = $urandom_range(0, 1) ? -adx : adx;
            dy = $urandom_range(0, 1) ? -ady : ady;
            sx = -32768 + $urandom_range(0, 65535 - adx) + ((dx < 0) ? adx : 0);
            sy = -32768 + $urandom_range(0, 65535 - ady) + ((dy < 0) ? ady : 0);
            send_item(IN_W'(sx), IN_W'(sy), IN_W'(sx + dx), IN_W'(sy + dy));
        end
    endtask

    task automatic test_directed_runs();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        write_step_size(10'd1);
        send_item(0, 0, 0, 0);
        send_item(5, -3, 6, -3);
        send_item(0, 0, -7, 3);
        send_item(10, 10, 13, 14);
        send_item(0, 0, 64, 0);
        send_item(0, 0, 0, -65);
        send_item(-32768, -32768, 32767, 32767);
        send_item(32767, 32767, -32768, -32768);
        send_item(-32768, 32767, 32767, -32768);
        send_item(32767, -32768, 32767, -32768);
        send_item(-1, -1, -3, -2);
        send_item(100, -100, 97, -96);
        wait_for_results(IDLE_PAD);
        write_step_size(10'd1023);
        send_item(0, 0, 1022, 0);
        send_item(0, 0, 1023, 0);
        send_item(-1000, -1000, 1046, -1000);
        send_item(-32768, -32768, 32767, 32767);
        send_item(0, 0, -3000, 4000);
        wait_for_results(IDLE_PAD);
        // A zero step size behaves as a step of one pixel.
        write_step_size(10'd0);
        send_item(0, 0, 3, 4);
        send_item(0, 0, -1, 0);
        send_item(7, 7, 7, 7);
        wait_for_results(IDLE_PAD);
    endtask

    task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct,
                                    input logic [STEP_W-1:0] step);
        write_step_size(step);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) send_random_run();
        wait_for_results(IDLE_PAD);
    endtask

    task automatic test_random_traffic();
        run_random_phase(70, 0, 0, 10'd1);
        run_random_phase(70, 74, 0, 10'd1023);
        run_random_phase(70, 0, 74, STEP_W'($urandom_range(2, 200)));
        run_random_phase(70, 35, 35, STEP_W'($urandom_range(1, 1023)));
    endtask

    task automatic test_input_backpressure();
        write_step_size(10'd1);
        sender_idle_pct = 0;
        receiver_stall_pct = 10;
        @(posedge clk);
        hold_off_cycles = HOLD_OFF;
        repeat (8) send_random_run();
        wait_for_results(IDLE_PAD);
    endtask

    task automatic test_paced_sender();
        write_step_size(STEP_W'($urandom_range(1, 40)));
        sender_idle_pct = 20;
        receiver_stall_pct = 30;
        repeat (5)
        begin
            send_random_run();
            wait_for_results(1);
        end
        wait_for_results(IDLE_PAD);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_valid = 1'b0;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        point_ready = 1'b0;
        step_setting = STEP_RESET;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_cycles = 0;
        mismatch_count = 0;
        runs_sent = 0;
        clipped_runs = 0;
        points_seen = 0;
        runs_seen = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_runs();
        test_random_traffic();
        test_input_backpressure();
        test_paced_sender();

        wait_for_results(END_PAD);
        $display("Covered %0d trajectories (%0d clipped) and %0d points, runs ending %0d,",
                 runs_sent, clipped_runs, points_seen, runs_seen);
        $display("over step sizes 0 to 1023 with sender idling, receiver stalls and a long hold-off.");
        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    initial
    begin
        #50000000;
        $display("Timed out with %0d points still expected.", expected_points.size());
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lts_pkg.sv
rtl/lts_engine.sv
rtl/line_trajectory_sampler.sv
rtl/lts_checker.sv
sim/testbench.sv
